[rtl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// Byte pattern search package
// Shared widths, register indexes, defaults and payload types for the
// byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Default sizes of the search window and of the range offset counter.
  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed field widths.
  localparam int BYTE_W      = 8;
  localparam int PAT_HALF_W  = 64;
  localparam int PAT_W       = 2 * PAT_HALF_W;
  localparam int LEN_W       = 5;
  localparam int RES_OFF_W   = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  // One text request.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;
  } text_item_t;

  // One result request.
  typedef struct packed {
    logic                 found;
    logic [RES_OFF_W-1:0] match_start;
    logic [RES_OFF_W-1:0] match_end;
  } result_item_t;

endpackage

[rtl/bps_matcher.sv]
// ----------------------------------------------------------------------------
// Byte pattern search window matcher
// Holds the text window, the range offset counter and the done flag, and
// compares the updated window against the pattern for every accepted byte.
// ----------------------------------------------------------------------------
module bps_matcher #(
  parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = bps_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  bps_pkg::text_item_t          item,
  input  logic [bps_pkg::PAT_W-1:0]    pattern,
  input  logic [bps_pkg::LEN_W-1:0]    pattern_length,
  output logic                         res_valid,
  output bps_pkg::result_item_t        res_item
);

  localparam int LEN_EFF_W = $clog2(MAX_PATTERN + 1);
  localparam int BW        = bps_pkg::BYTE_W;
  localparam int RW        = bps_pkg::RES_OFF_W;

  // Window with the newest byte at index zero.
  logic [BW-1:0]          window [MAX_PATTERN];
  logic [BW-1:0]          window_next [MAX_PATTERN];
  logic [BW-1:0]          window_shift [MAX_PATTERN];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic [OFFSET_BITS-1:0] shifted_count;
  logic [OFFSET_BITS-1:0] start_offset;
  logic                   match_done;
  logic                   match_done_next;
  logic [LEN_EFF_W-1:0]   len_eff;
  logic [MAX_PATTERN:0]   hit_len;
  logic                   hit;

  // Lengths above the window depth are treated as the full window.
  always_comb begin
    if (pattern_length > bps_pkg::LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_EFF_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length[LEN_EFF_W-1:0];
    end
  end

  // Saturating count including the byte being taken.
  assign shifted_count = (bytes_seen == '1) ? bytes_seen : bytes_seen + 1'b1;

  // Window as it looks once the incoming byte is shifted in.
  always_comb begin
    window_shift[0] = item.text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_shift[j] = window[j-1];
    end
  end

  // Compare the shifted window for every candidate length in parallel.
  always_comb begin
    hit_len = '0;
    for (int len = 1; len <= MAX_PATTERN; len++) begin
      hit_len[len] = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (window_shift[len - 1 - i] != pattern[BW*i +: BW]) begin
          hit_len[len] = 1'b0;
        end
      end
    end
  end

  assign hit = hit_len[len_eff] && (shifted_count >= OFFSET_BITS'(len_eff));
  assign start_offset = shifted_count - OFFSET_BITS'(len_eff);

  // Next state of the window, the counter and the done flag.
  always_comb begin
    window_next     = window;
    bytes_seen_next = bytes_seen;
    match_done_next = match_done;
    res_valid       = 1'b0;
    res_item        = '0;
    if (accept) begin
      if (match_done) begin
        // Rest of the range after a match is dropped.
        if (item.last_byte) begin
          for (int j = 0; j < MAX_PATTERN; j++) begin
            window_next[j] = '0;
          end
          bytes_seen_next = '0;
          match_done_next = 1'b0;
        end
      end else begin
        window_next     = window_shift;
        bytes_seen_next = shifted_count;
        if (hit || item.last_byte) begin
          res_valid = 1'b1;
        end
        if (hit) begin
          res_item.found       = 1'b1;
          res_item.match_start = RW'({RW'(0), start_offset});
          res_item.match_end   = RW'({RW'(0), shifted_count});
          match_done_next      = 1'b1;
        end
        if (item.last_byte) begin
          for (int j = 0; j < MAX_PATTERN; j++) begin
            window_next[j] = '0;
          end
          bytes_seen_next = '0;
          match_done_next = 1'b0;
        end
      end
    end
  end

  // Range state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window[j] <= '0;
      end
      bytes_seen <= '0;
      match_done <= 1'b0;
    end else begin
      window     <= window_next;
      bytes_seen <= bytes_seen_next;
      match_done <= match_done_next;
    end
  end

  // A match inside a range blocks further results until the range ends.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.found && !item.last_byte |=> match_done)
    else $error("match_done not set after a match inside a range");

  // The last byte of a range always restarts the range state.
  assert property (@(posedge clk) disable iff (rst)
    accept && item.last_byte |=> (bytes_seen == '0) && !match_done)
    else $error("range state not cleared after last byte");

  // A not-found result carries zero offsets.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.found |->
      (res_item.match_start == '0) && (res_item.match_end == '0))
    else $error("not-found result with nonzero offsets");

endmodule

[rtl/bps_result_buf.sv]
// ----------------------------------------------------------------------------
// Byte pattern search result buffer
// Output register with a skid stage so that the matcher keeps taking bytes
// while a result waits for the downstream side.
// ----------------------------------------------------------------------------
module bps_result_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bps_pkg::result_item_t push_item,
  output logic                  full,
  output logic                  result_valid,
  input  logic                  result_stall,
  output bps_pkg::result_item_t result_item
);

  logic                  skid_valid;
  bps_pkg::result_item_t skid_item;
  logic                  pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result_item <= skid_item;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_item <= push_item;
      end else begin
        result_item <= push_item;
      end
    end
  end

  // The skid stage only holds a request behind a waiting output.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage holds a request while the output is empty");

  // A request pushed behind a stalled output lands in the skid stage.
  assert property (@(posedge clk) disable iff (rst)
    push && result_valid && result_stall |=> skid_valid)
    else $error("request lost behind a stalled output");

  // A skid stage under an unstalled output is empty in the next cycle, since no push can arrive.
  assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result_stall |=> !skid_valid)
    else $error("skid stage did not drain");

endmodule

[rtl/byte_pattern_search.sv]
// ----------------------------------------------------------------------------
// Byte pattern search
// Finds the first exact occurrence of a configured pattern of up to
// MAX_PATTERN bytes in each range of a text byte stream.
// ----------------------------------------------------------------------------
// Each result is registered before it reaches the result outputs.
// Throughput: one text byte per cycle; the window compare is one registered
// pass of parallel byte compares, and results leave through an output
// register backed by a one-entry skid stage (text_stall rises when it fills).
// Reset clears the pattern registers, the window, the offset counter and both
// result slots.
module byte_pattern_search #(
  parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = bps_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              text_valid,
  output logic                              text_stall,
  input  bps_pkg::text_item_t               text_item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bps_pkg::result_item_t             result_item,
  input  logic                              cfg_write,
  input  logic [bps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [bps_pkg::PAT_HALF_W-1:0] pattern_low;
  logic [bps_pkg::PAT_HALF_W-1:0] pattern_high;
  logic [bps_pkg::LEN_W-1:0]      pattern_length;
  logic                           text_accept;
  logic                           res_valid;
  bps_pkg::result_item_t          res_item;
  logic                           buf_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bps_pkg::CFG_PATTERN_LOW: begin
          pattern_low <= cfg_data;
        end
        bps_pkg::CFG_PATTERN_HIGH: begin
          pattern_high <= cfg_data;
        end
        bps_pkg::CFG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[bps_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A text request is taken whenever the skid stage has room.
  assign text_stall  = buf_full;
  assign text_accept = text_valid && !text_stall;

  bps_matcher #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_matcher (
    .clk            (clk),
    .rst            (rst),
    .accept         (text_accept),
    .item           (text_item),
    .pattern        ({pattern_high, pattern_low}),
    .pattern_length (pattern_length),
    .res_valid      (res_valid),
    .res_item       (res_item)
  );

  bps_result_buf u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_item    (res_item),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

[tb/tb_byte_pattern_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte pattern search testbench
// Drives ranges of text bytes into the search block under several pattern
// settings. The first part walks a short table of directed requests, and a
// random part follows: ranges that hold the pattern, broken copies of it,
// truncated prefixes and plain noise. Every result is checked field by field
// against a table entry or an in-bench search model, with random idle
// cycles on both sides and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_byte_pattern_search;

  localparam int MAX_PAT      = bps_pkg::MAX_PATTERN_DEF;
  localparam int BYTE_W       = bps_pkg::BYTE_W;
  localparam int PAT_HALF_W   = bps_pkg::PAT_HALF_W;
  localparam int PAT_W        = bps_pkg::PAT_W;
  localparam int LEN_W        = bps_pkg::LEN_W;
  localparam int RES_OFF_W    = bps_pkg::RES_OFF_W;
  localparam int CFG_INDEX_W  = bps_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W   = bps_pkg::CFG_DATA_W;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE       = 4;
  localparam int HOLD_CYCLES  = 80;

  typedef enum logic {ROW_TEXT, ROW_CONFIG} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} row_exp_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0]   value;
    logic                    is_last;
    row_exp_t                exp;
    bps_pkg::result_item_t   want;
  } stim_row_t;

  // Block ports.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   text_valid = 1'b0;
  logic                   text_stall;
  bps_pkg::text_item_t    text_item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  bps_pkg::result_item_t  result_item;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Search model state and its copy of the registers.
  logic [PAT_HALF_W-1:0]  pat_lo;
  logic [PAT_HALF_W-1:0]  pat_hi;
  logic [LEN_W-1:0]       pat_len;
  logic [BYTE_W-1:0]      win_bytes [MAX_PAT];
  logic [RES_OFF_W-1:0]   seen_count;
  bit                     range_matched;

  bps_pkg::result_item_t pending_results [$];
  stim_row_t             script [$];
  bps_pkg::result_item_t want_item;

  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  matches_seen = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  steady = 1'b0;

  byte_pattern_search DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("byte_pattern_search verification failed");
    $finish;
  end

  // Random idle decision shared by both sides.
  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 19);
  endfunction

  function automatic stim_row_t row(input row_kind_t kind, input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value, input logic is_last,
                                    input row_exp_t exp, input logic f,
                                    input logic [RES_OFF_W-1:0] s,
                                    input logic [RES_OFF_W-1:0] e);
    stim_row_t r;
    r.kind = kind;
    r.cfg_idx = idx;
    r.value = value;
    r.is_last = is_last;
    r.exp = exp;
    r.want.found = f;
    r.want.match_start = s;
    r.want.match_end = e;
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input stim_row_t r);
    script.insert(script.size(), r);
  endfunction

  // Queue one expected result behind the ones already waiting.
  function automatic void expect_result(input bps_pkg::result_item_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Start a new range in the model.
  function automatic void clear_range();
    foreach (win_bytes[i]) win_bytes[i] = '0;
    seen_count = '0;
    range_matched = 1'b0;
  endfunction

  // Model of one text byte: shift the window, count the byte and compare.
  task automatic search_step(input logic [BYTE_W-1:0] v, input logic is_last,
                             output bit produced, output bps_pkg::result_item_t r);
    int n;
    bit hit;
    logic [PAT_W-1:0] pat;
    produced = 1'b0;
    r = '0;
    if (range_matched) begin
      if (is_last) clear_range();
      return;
    end
    for (int i = MAX_PAT - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = v;
    if (seen_count != '1) seen_count++;
    n = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
    hit = (n != 0) && (seen_count >= RES_OFF_W'(n));
    pat = {pat_hi, pat_lo};
    for (int i = 0; i < n; i++) begin
      if (win_bytes[n-1-i] != pat[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      produced = 1'b1;
      r.found = 1'b1;
      r.match_start = seen_count - RES_OFF_W'(n);
      r.match_end = seen_count;
      if (is_last) clear_range();
      else range_matched = 1'b1;
    end else if (is_last) begin
      produced = 1'b1;
      clear_range();
    end
  endtask

  // Offer one text request and wait until the block takes it.
  task automatic drive_text(input logic [BYTE_W-1:0] v, input logic is_last);
    @(negedge clk);
    while (take_gap()) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_item.text_byte <= v;
    text_item.last_byte <= is_last;
    do @(posedge clk); while (text_stall);
    items_sent++;
  endtask

  task automatic send_predicted(input logic [BYTE_W-1:0] v, input logic is_last);
    bit produced;
    bps_pkg::result_item_t r;
    drive_text(v, is_last);
    search_step(v, is_last, produced, r);
    if (produced) expect_result(r);
  endtask

  // Stop offering, drain every expected result and let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    text_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      bps_pkg::CFG_PATTERN_LOW:    pat_lo = data;
      bps_pkg::CFG_PATTERN_HIGH:   pat_hi = data;
      bps_pkg::CFG_PATTERN_LENGTH: pat_len = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Filler byte: either fully random or drawn from the pattern itself.
  function automatic logic [BYTE_W-1:0] pick_filler(input bit narrow, input int n);
    logic [PAT_W-1:0] pat;
    int k;
    pat = {pat_hi, pat_lo};
    if (narrow && n > 0 && $urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, n - 1);
      return pat[8*k +: 8];
    end
    return BYTE_W'($urandom);
  endfunction

  // One random range: mostly holding the pattern, sometimes a broken or
  // truncated copy, sometimes plain noise.
  task automatic send_range();
    logic [BYTE_W-1:0] range_q [$];
    logic [PAT_W-1:0] pat;
    int n;
    int span;
    int mode;
    int pos;
    int k;
    bit narrow;
    pat = {pat_hi, pat_lo};
    n = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
    span = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
    mode = $urandom_range(0, 9);
    narrow = $urandom_range(0, 1);
    if (n > 0 && mode < 9 && span < n) span = n + $urandom_range(0, 4);
    for (int i = 0; i < span; i++) range_q.insert(range_q.size(), pick_filler(narrow, n));
    if (n > 0 && mode <= 7) begin
      pos = $urandom_range(0, span - n);
      for (int i = 0; i < n; i++) range_q[pos+i] = pat[8*i +: 8];
      // Broken copy: one byte of the pattern is altered.
      if (mode >= 6) begin
        k = $urandom_range(0, n - 1);
        range_q[pos+k] = range_q[pos+k] ^ BYTE_W'($urandom_range(1, 255));
      end
    end else if (n > 1 && mode == 8) begin
      // Truncated copy: only a prefix fits before the range ends.
      k = $urandom_range(1, n - 1);
      for (int i = 0; i < k; i++) range_q[span-k+i] = pat[8*i +: 8];
    end
    for (int i = 0; i < span; i++) send_predicted(range_q[i], i == span - 1);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= take_gap();
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result with none expected: found=%0d match_start=%0d match_end=%0d",
               result_item.found, result_item.match_start, result_item.match_end);
      end else begin
        want_item = pending_results.pop_front();
        if (want_item.found) matches_seen++;
        if (result_item.found !== want_item.found) begin
          fail_count++;
          $error("found: expected %0d, actual %0d", want_item.found, result_item.found);
        end
        if (result_item.match_start !== want_item.match_start) begin
          fail_count++;
          $error("match_start: expected %0d, actual %0d",
                 want_item.match_start, result_item.match_start);
        end
        if (result_item.match_end !== want_item.match_end) begin
          fail_count++;
          $error("match_end: expected %0d, actual %0d",
                 want_item.match_end, result_item.match_end);
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    bit produced;
    bps_pkg::result_item_t predicted;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] len_data;
    int len;
    int phase;
    int phase_start;
    int directed_items;
    bit pressure_done;
    bit steady_done;

    pat_lo = '0;
    pat_hi = '0;
    pat_len = '0;
    clear_range();
    pressure_done = 1'b0;
    steady_done = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Registers at reset: zero length never matches.
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'h00, 1'b1,
                EXP_GIVEN, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'hFF, 1'b1,
                EXP_GIVEN, 1'b0, 32'd0, 32'd0));
    // Two-byte pattern FF 00: match, ignored tail, then a match on the last byte.
    add_row(row(ROW_CONFIG, bps_pkg::CFG_PATTERN_LOW, 64'h00FF, 1'b0,
                EXP_NONE, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_CONFIG, bps_pkg::CFG_PATTERN_LENGTH, 64'd2, 1'b0,
                EXP_NONE, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'hFF, 1'b0,
                EXP_NONE, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'h00, 1'b0,
                EXP_GIVEN, 1'b1, 32'd0, 32'd2));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'h00, 1'b1,
                EXP_NONE, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'h11, 1'b0,
                EXP_MODEL, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'hFF, 1'b0,
                EXP_MODEL, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'h00, 1'b1,
                EXP_GIVEN, 1'b1, 32'd1, 32'd3));
    // Open a range, then switch to an all-ones pattern with an oversized
    // length in the middle of it; the length saturates to the window size.
    for (int i = 0; i < 4; i++)
      add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'hFF, 1'b0,
                  EXP_MODEL, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_CONFIG, bps_pkg::CFG_PATTERN_LOW, '1, 1'b0,
                EXP_NONE, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_CONFIG, bps_pkg::CFG_PATTERN_HIGH, '1, 1'b0,
                EXP_NONE, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_CONFIG, bps_pkg::CFG_PATTERN_LENGTH, '1, 1'b0,
                EXP_NONE, 1'b0, 32'd0, 32'd0));
    for (int i = 0; i < 11; i++)
      add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'hFF, 1'b0,
                  EXP_MODEL, 1'b0, 32'd0, 32'd0));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'hFF, 1'b0,
                EXP_GIVEN, 1'b1, 32'd0, 32'd16));
    add_row(row(ROW_TEXT, bps_pkg::CFG_PATTERN_LOW, 64'h5A, 1'b1,
                EXP_NONE, 1'b0, 32'd0, 32'd0));

    foreach (script[k]) begin
      if (script[k].kind == ROW_CONFIG) begin
        wait_idle();
        write_register(script[k].cfg_idx, script[k].value);
      end else begin
        drive_text(script[k].value[BYTE_W-1:0], script[k].is_last);
        search_step(script[k].value[BYTE_W-1:0], script[k].is_last, produced, predicted);
        case (script[k].exp)
          EXP_GIVEN: expect_result(script[k].want);
          EXP_MODEL: if (produced) expect_result(predicted);
          default: ;
        endcase
      end
    end
    settings_used = 3;
    directed_items = items_sent;

    // Random phases, each under its own pattern setting.
    phase = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      wait_idle();
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (phase % 8)
        0: len = 1;
        1: len = MAX_PAT;
        2: len = 0;
        3: begin
          len = MAX_PAT;
          lo = '0;
          hi = '0;
        end
        4: len = $urandom_range(1, MAX_PAT);
        5: begin
          len = 9;
          lo = '1;
          hi = '1;
        end
        6: len = $urandom_range(MAX_PAT + 1, 31);
        default: len = 8;
      endcase
      // Upper data bits are don't-care for the length register.
      len_data = {$urandom, $urandom};
      if (phase % 8 != 6) len_data[CFG_DATA_W-1:LEN_W] = '0;
      len_data[LEN_W-1:0] = LEN_W'(len);
      write_register(bps_pkg::CFG_PATTERN_LOW, lo);
      write_register(bps_pkg::CFG_PATTERN_HIGH, hi);
      write_register(bps_pkg::CFG_PATTERN_LENGTH, len_data);
      settings_used++;

      steady = (phase % 8 == 4) && !steady_done;
      if (steady) steady_done = 1'b1;
      phase_start = items_sent;

      // With zero length every one-byte range yields a result: hold the
      // output off so the result buffer fills and the input stalls.
      if (phase % 8 == 2 && !pressure_done) begin
        pressure_done = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_predicted(BYTE_W'($urandom), 1'b1);
      end
      while (items_sent - phase_start < PHASE_ITEMS) send_range();
      steady = 1'b0;
      phase++;
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d text bytes over %0d pattern settings.", items_sent, settings_used);
    $display("Checked %0d results, %0d of them matches.", results_seen, matches_seen);
    if (fail_count == 0) begin
      $display("byte_pattern_search verification clean");
    end else begin
      $display("byte_pattern_search verification failed");
    end
    $finish;
  end

endmodule
